/* rtl/rc4_pkg.sv */
// rc4_pkg: shared types and constants for the rc4 stream cipher
// request mode codes, permutation size, control and result structs
// no dependencies
package rc4_pkg;

  localparam int unsigned PERM_SIZE = 256;

  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_CIPHER  = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;

  typedef struct packed {
    logic restart;
    logic rd;
    logic done;
  } kctl_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       keyed;
  } res_t;

endpackage

/* rtl/rc4_key_mem.sv */
// rc4_key_mem: key byte store with fill count and wrapping read index
// write side is fed by key load requests, read side by the key schedule
// depends on rc4_pkg
module rc4_key_mem #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_req_i,
  input  logic [7:0]     byte_i,
  input  rc4_pkg::kctl_t kctl_i,
  output logic [7:0]     key_byte_o
);

  localparam int unsigned AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int unsigned CW = $clog2(KEY_MAX + 1);

  logic [7:0]    key_mem [KEY_MAX];
  logic [CW-1:0] count_q;
  logic [AW-1:0] kidx_q;
  logic [7:0]    kdata_q;
  logic          wr_en;
  logic          wrap;

  assign wr_en      = wr_req_i && (count_q < CW'(KEY_MAX));
  assign wrap       = (CW'(kidx_q) == (count_q - CW'(1)));
  assign key_byte_o = kdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[count_q[AW-1:0]] <= byte_i;
    end
    if (kctl_i.rd) begin
      kdata_q <= key_mem[kidx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kidx_q  <= '0;
    end else begin
      if (kctl_i.done) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + CW'(1);
      end
      if (kctl_i.restart) begin
        kidx_q <= '0;
      end else if (kctl_i.rd) begin
        kidx_q <= wrap ? '0 : kidx_q + AW'(1);
      end
    end
  end

endmodule

/* rtl/rc4_engine.sv */
// rc4_engine: permutation memory with key schedule and keystream sequencer
// one read and one write port per cycle, forwarding on the final lookup
// depends on rc4_pkg
module rc4_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_acc_i,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      byte_in_i,
  input  logic            key_last_i,
  input  logic [7:0]      key_byte_i,
  input  logic            slot_free_i,
  output logic            busy_o,
  output rc4_pkg::kctl_t  kctl_o,
  output rc4_pkg::res_t   res_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GJ,
    ST_GT,
    ST_GW,
    ST_HOLD,
    ST_KRD,
    ST_KJ,
    ST_KS1,
    ST_KS2
  } state_e;

  state_e state_q;

  logic [7:0] perm_mem [rc4_pkg::PERM_SIZE];
  logic [rc4_pkg::PERM_SIZE-1:0] valid_q;
  logic [7:0] prd_q;
  logic       pvld_q;
  logic [7:0] praddr_q;
  logic [7:0] pdata;

  logic [7:0] raddr;
  logic [7:0] waddr;
  logic [7:0] wdata;
  logic       we;

  logic [7:0] i_q;
  logic [7:0] j_q;
  logic [7:0] si_q;
  logic [7:0] sj_q;
  logic [7:0] byte_q;
  logic [7:0] ks_q;
  logic       cipher_q;
  logic       keyed_q;

  logic       start_sched;
  logic [7:0] fwd;

  assign pdata       = pvld_q ? prd_q : praddr_q;
  assign start_sched = (state_q == ST_IDLE) && req_acc_i
                       && (mode_i == rc4_pkg::MODE_KEY) && key_last_i;
  assign busy_o      = (state_q != ST_IDLE);

  // last swap write to j lands after the read, so forward both swapped entries
  assign fwd = (praddr_q == j_q) ? si_q :
               (praddr_q == i_q) ? sj_q : pdata;

  always_comb begin
    raddr          = i_q;
    we             = 1'b0;
    waddr          = i_q;
    wdata          = pdata;
    kctl_o         = '0;
    kctl_o.restart = start_sched;
    res_o          = '0;
    res_o.keyed    = keyed_q;
    case (state_q)
      ST_IDLE: begin
        raddr = i_q + 8'd1;
      end
      ST_GJ: begin
        raddr = j_q + pdata;
      end
      ST_GT: begin
        raddr = si_q + pdata;
        we    = 1'b1;
        waddr = i_q;
        wdata = pdata;
      end
      ST_GW: begin
        we         = 1'b1;
        waddr      = j_q;
        wdata      = si_q;
        res_o.vld  = cipher_q && slot_free_i;
        res_o.data = byte_q ^ fwd;
      end
      ST_HOLD: begin
        res_o.vld  = slot_free_i;
        res_o.data = ks_q;
      end
      ST_KRD: begin
        raddr     = i_q;
        kctl_o.rd = 1'b1;
      end
      ST_KJ: begin
        raddr = j_q + pdata + key_byte_i;
      end
      ST_KS1: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = pdata;
      end
      ST_KS2: begin
        we          = 1'b1;
        waddr       = j_q;
        wdata       = si_q;
        kctl_o.done = (i_q == 8'hff);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    prd_q    <= perm_mem[raddr];
    pvld_q   <= valid_q[raddr];
    praddr_q <= raddr;
  end

  // entries not yet written read back as their own index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (start_sched) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      si_q     <= '0;
      sj_q     <= '0;
      byte_q   <= '0;
      ks_q     <= '0;
      cipher_q <= 1'b0;
      keyed_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_acc_i) begin
            case (mode_i)
              rc4_pkg::MODE_KEY: begin
                if (key_last_i) begin
                  i_q     <= '0;
                  j_q     <= '0;
                  state_q <= ST_KRD;
                end
              end
              rc4_pkg::MODE_CIPHER, rc4_pkg::MODE_ADVANCE: begin
                i_q      <= i_q + 8'd1;
                byte_q   <= byte_in_i;
                cipher_q <= (mode_i == rc4_pkg::MODE_CIPHER);
                state_q  <= ST_GJ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_GJ: begin
          si_q    <= pdata;
          j_q     <= j_q + pdata;
          state_q <= ST_GT;
        end
        ST_GT: begin
          sj_q    <= pdata;
          state_q <= ST_GW;
        end
        ST_GW: begin
          if (cipher_q && !slot_free_i) begin
            ks_q    <= byte_q ^ fwd;
            state_q <= ST_HOLD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_HOLD: begin
          if (slot_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        ST_KRD: begin
          state_q <= ST_KJ;
        end
        ST_KJ: begin
          si_q    <= pdata;
          j_q     <= j_q + pdata + key_byte_i;
          state_q <= ST_KS1;
        end
        ST_KS1: begin
          state_q <= ST_KS2;
        end
        ST_KS2: begin
          if (i_q == 8'hff) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            i_q     <= i_q + 8'd1;
            state_q <= ST_KRD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/rc4_stream_cipher.sv */
// rc4_stream_cipher: byte-wise RC4 with key load, cipher and advance-only requests;
// built from rc4_key_mem (key store) and rc4_engine (permutation memory and
// sequencer), types from rc4_pkg. The key byte request marked key_last runs
// the key schedule, four steps per permutation entry (read, index update, two swap
// writes on the single write port), and the input stalls meanwhile. A cipher or
// advance request occupies the engine for the dependent reads and the two swap writes
// in the permutation memory, and a cipher result goes from the last swap-write state
// into the output register. A stalled output register holds the engine until the
// result can be handed over.
module rc4_stream_cipher #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] byte_in_i,
  input  logic       key_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_out_o,
  output logic       keyed_o
);

  logic           req_acc;
  logic           busy;
  logic           slot_free;
  logic [7:0]     key_byte;
  rc4_pkg::kctl_t kctl;
  rc4_pkg::res_t  res;

  logic       out_valid_q;
  logic [7:0] byte_out_q;
  logic       keyed_q;

  assign in_stall_o  = busy;
  assign req_acc     = in_valid_i && !busy;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_out_q;
  assign keyed_o     = keyed_q;

  rc4_key_mem #(
    .KEY_MAX (KEY_MAX)
  ) u_key_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_req_i   (req_acc && (mode_i == rc4_pkg::MODE_KEY)),
    .byte_i     (byte_in_i),
    .kctl_i     (kctl),
    .key_byte_o (key_byte)
  );

  rc4_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_acc_i   (req_acc),
    .mode_i      (mode_i),
    .byte_in_i   (byte_in_i),
    .key_last_i  (key_last_i),
    .key_byte_i  (key_byte),
    .slot_free_i (slot_free),
    .busy_o      (busy),
    .kctl_o      (kctl),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.vld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      byte_out_q <= res.data;
      keyed_q    <= res.keyed;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |-> (!out_valid_q || !out_stall_i))
  else $error("result handed over while output register is blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (mode_i == rc4_pkg::MODE_KEY) && key_last_i) |=> in_stall_o)
  else $error("key schedule did not start after final key byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && ((mode_i == rc4_pkg::MODE_CIPHER) || (mode_i == rc4_pkg::MODE_ADVANCE)))
    |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
  else $error("keystream step finished early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kctl.rd || kctl.done) |-> in_stall_o)
  else $error("key store accessed by schedule while idle");

endmodule

/* tb/rc4_checker.sv */
// rc4_checker: watches the request and result channels of rc4_stream_cipher, keeps its
// own rc4 state, predicts every cipher result and compares it field by field
// depends on rc4_pkg for the mode codes and the permutation size
`timescale 1ns / 1ps

module rc4_checker #(
  parameter int unsigned KEY_MAX = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] byte_in_i,
  input  logic       key_last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] byte_out_i,
  input  logic       keyed_i,
  output int         mismatch_cnt_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       keyed;
  } cipher_byte_t;

  logic [7:0]   sbox [rc4_pkg::PERM_SIZE];
  logic [7:0]   key_bytes [KEY_MAX];
  logic [8:0]   key_len;
  logic [7:0]   idx_i;
  logic [7:0]   idx_j;
  logic         keyed_q;
  cipher_byte_t cipher_q [$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  task automatic swap_sbox(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] t;
    t       = sbox[a];
    sbox[a] = sbox[b];
    sbox[b] = t;
  endtask

  task automatic clear_state();
    for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) sbox[n] = n[7:0];
    key_len = '0;
    idx_i   = '0;
    idx_j   = '0;
    keyed_q = 1'b0;
    cipher_q.delete();
  endtask

  task automatic schedule_key();
    int unsigned len;
    logic [7:0]  acc;
    len = key_len;
    if (len == 0) len = 1;
    if (len > KEY_MAX) len = KEY_MAX;
    for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) sbox[n] = n[7:0];
    acc = '0;
    for (int n = 0; n < rc4_pkg::PERM_SIZE; n++) begin
      acc = acc + sbox[n] + key_bytes[n % len];
      swap_sbox(n[7:0], acc);
    end
    idx_i   = '0;
    idx_j   = '0;
    key_len = '0;
    keyed_q = 1'b1;
  endtask

  task automatic next_keystream(output logic [7:0] ks);
    logic [7:0] pick;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    swap_sbox(idx_i, idx_j);
    pick = sbox[idx_i] + sbox[idx_j];
    ks   = sbox[pick];
  endtask

  task automatic apply_request(input logic [1:0] mode, input logic [7:0] din,
                               input logic last);
    logic [7:0]   ks;
    cipher_byte_t res;
    case (mode)
      rc4_pkg::MODE_KEY: begin
        if (key_len < KEY_MAX) begin
          key_bytes[key_len] = din;
          key_len            = key_len + 9'd1;
        end
        if (last) schedule_key();
      end
      rc4_pkg::MODE_CIPHER: begin
        next_keystream(ks);
        res.data  = din ^ ks;
        res.keyed = keyed_q;
        cipher_q.push_back(res);
      end
      rc4_pkg::MODE_ADVANCE: begin
        next_keystream(ks);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    cipher_byte_t exp;
    if (cipher_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual byte_out %02h keyed %0b",
               $time, byte_out_i, keyed_i);
      mismatch_cnt_o++;
    end else begin
      exp = cipher_q.pop_front();
      if (byte_out_i !== exp.data) begin
        $display("%0t: byte_out mismatch, expected %02h, actual %02h",
                 $time, exp.data, byte_out_i);
        mismatch_cnt_o++;
      end
      if (keyed_i !== exp.keyed) begin
        $display("%0t: keyed mismatch, expected %0b, actual %0b",
                 $time, exp.keyed, keyed_i);
        mismatch_cnt_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (in_valid_i && !in_stall_i) apply_request(mode_i, byte_in_i, key_last_i);
      if (out_valid_i && !out_stall_i) check_result();
    end
    pending_o = cipher_q.size();
  end

endmodule

/* tb/tb_top.sv */
// tb_top: drives rc4_stream_cipher with directed and random key, cipher and
// advance requests under random idling on both sides; rc4_checker judges results
// depends on rc4_pkg, rc4_stream_cipher and rc4_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned KEY_MAX     = 256;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int          NUM_REQS    = 1300;
  localparam int          CYCLE_LIMIT = 1000000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] mode_i;
  logic [7:0] byte_in_i;
  logic       key_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] byte_out_o;
  logic       keyed_o;

  int mismatch_cnt;
  int pending;
  int req_cnt;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;

  rc4_stream_cipher #(
    .KEY_MAX(KEY_MAX)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .byte_in_i  (byte_in_i),
    .key_last_i (key_last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .byte_out_o (byte_out_o),
    .keyed_o    (keyed_o)
  );

  rc4_checker #(
    .KEY_MAX(KEY_MAX)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .mode_i        (mode_i),
    .byte_in_i     (byte_in_i),
    .key_last_i    (key_last_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_i    (byte_out_o),
    .keyed_i       (keyed_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = rc4_pkg::MODE_KEY;
    byte_in_i     = '0;
    key_last_i    = 1'b0;
    out_stall_i   = 1'b0;
    cycles        = 0;
    req_cnt       = 0;
    send_idle_pct = 38;
    recv_idle_pct = 64;
  end

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // idling profile follows progress through the run
  task automatic send_req(input logic [1:0] mode, input logic [7:0] din, input logic last);
    logic taken;
    if (req_cnt < NUM_REQS / 3) begin
      send_idle_pct = 38;
      recv_idle_pct = 64;
    end else if (req_cnt < 2 * NUM_REQS / 3) begin
      send_idle_pct = 64;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    byte_in_i  <= din;
    key_last_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (mode != MODE_UNUSED) req_cnt++;
  endtask

  task automatic load_key(input int len);
    for (int k = 0; k < len; k++) begin
      send_req(rc4_pkg::MODE_KEY, 8'($urandom_range(0, 255)), k == len - 1);
    end
  endtask

  task automatic run_data(input int len);
    int         pick;
    logic [1:0] mode;
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) mode = rc4_pkg::MODE_CIPHER;
      else if (pick < 95) mode = rc4_pkg::MODE_ADVANCE;
      else mode = MODE_UNUSED;
      send_req(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no key yet: identity permutation, flag ignored outside key loads
    send_req(rc4_pkg::MODE_CIPHER, 8'h00, 1'b0);
    send_req(rc4_pkg::MODE_CIPHER, 8'hFF, 1'b1);
    send_req(rc4_pkg::MODE_ADVANCE, 8'h5A, 1'b1);
    send_req(MODE_UNUSED, 8'hFF, 1'b1);
    send_req(MODE_UNUSED, 8'h00, 1'b0);
    send_req(rc4_pkg::MODE_CIPHER, 8'h80, 1'b0);
    // one-byte key
    send_req(rc4_pkg::MODE_KEY, 8'hFF, 1'b1);
    send_req(rc4_pkg::MODE_CIPHER, 8'h00, 1'b0);
    send_req(rc4_pkg::MODE_CIPHER, 8'hFF, 1'b1);
    send_req(rc4_pkg::MODE_ADVANCE, 8'h00, 1'b0);
    send_req(rc4_pkg::MODE_CIPHER, 8'hA5, 1'b0);
    // three-byte key, then rekey
    send_req(rc4_pkg::MODE_KEY, 8'h00, 1'b0);
    send_req(rc4_pkg::MODE_KEY, 8'h80, 1'b0);
    send_req(rc4_pkg::MODE_KEY, 8'h7F, 1'b1);
    send_req(rc4_pkg::MODE_CIPHER, 8'h01, 1'b0);
    send_req(rc4_pkg::MODE_CIPHER, 8'hFE, 1'b0);
    send_req(rc4_pkg::MODE_ADVANCE, 8'hFF, 1'b1);
    send_req(rc4_pkg::MODE_CIPHER, 8'h55, 1'b1);
    send_req(rc4_pkg::MODE_KEY, 8'h01, 1'b1);
    send_req(rc4_pkg::MODE_CIPHER, 8'h00, 1'b0);
    send_req(rc4_pkg::MODE_CIPHER, 8'hFF, 1'b0);

    // key longer than the store
    load_key(KEY_MAX + 1 + $urandom_range(0, 8));
    run_data($urandom_range(4, 20));

    while (req_cnt < NUM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 39) == 0) load_key($urandom_range(KEY_MAX - 4, KEY_MAX + 8));
        else load_key($urandom_range(1, 16));
        run_data($urandom_range(4, 40));
      end else if (pick < 85) begin
        // broken key load followed by data requests
        load_key(0);
        for (int k = $urandom_range(1, 5); k > 0; k--) begin
          send_req(rc4_pkg::MODE_KEY, 8'($urandom_range(0, 255)), 1'b0);
        end
        run_data($urandom_range(1, 10));
      end else begin
        pick = $urandom_range(0, 3);
        send_req(pick[1:0], 8'($urandom_range(0, 255)),
                 (pick[1:0] == rc4_pkg::MODE_KEY) ? ($urandom_range(0, 99) < 30)
                                                  : 1'($urandom_range(0, 1)));
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rc4_pkg.sv
rtl/rc4_key_mem.sv
rtl/rc4_engine.sv
rtl/rc4_stream_cipher.sv
tb/rc4_checker.sv
tb/tb_top.sv
